// ===== hw/rtl/http_response_head_parser_assert.svh =====
// ----------------------------------------------------------------------------
// http response head parser assertion macros
// concurrent checks clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef HTTP_RESPONSE_HEAD_PARSER_ASSERT_SVH
`define HTTP_RESPONSE_HEAD_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define HRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HRP_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define HRP_ASSERT(lbl, prop, msg)
`define HRP_NEVER(lbl, expr, msg)
`endif

`endif

// ===== hw/rtl/hrp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrp_pkg
// types and constants shared by the http response head parser modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hrp_pkg;

  typedef enum logic [2:0] {
    PH_STATUS,
    PH_HEAD,
    PH_BODY,
    PH_DONE,
    PH_ERR
  } phase_e;

  typedef enum logic [2:0] {
    EV_MORE     = 3'd0,
    EV_STATUS   = 3'd1,
    EV_HEADER   = 3'd2,
    EV_BODY     = 3'd3,
    EV_COMPLETE = 3'd4,
    EV_ERR      = 3'd5
  } event_e;

  typedef enum logic [3:0] {
    ST_H, ST_T1, ST_T2, ST_P, ST_SLASH, ST_MAJ0, ST_MAJ, ST_MIN0, ST_MIN,
    ST_CODE, ST_AFTER, ST_TEXT, ST_CR
  } status_e;

  typedef enum logic [2:0] {
    H_START, H_NAME, H_PRE, H_VALUE, H_POST, H_IGNORE, H_ALMOST, H_END_CR
  } header_e;

  localparam int ClLen   = 14;
  localparam int HttpLen = 4;
  localparam int CodeDigits = 3;
  localparam logic [7:0] ChCr = 8'd13;
  localparam logic [7:0] ChLf = 8'd10;

  localparam logic [7:0] ClPrefix [ClLen] = '{
    "C", "o", "n", "t", "e", "n", "t", "-", "L", "e", "n", "g", "t", "h"
  };
  localparam logic [7:0] HttpPrefix [HttpLen] = '{"H", "T", "T", "P"};

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        new_resp;
    logic        digit;
    logic [7:0]  name_c;     // lowercase name char, zero when not allowed
    logic        is_cr;
    logic        is_lf;
    logic        is_sp;
    logic        is_dot;
    logic        is_colon;
    logic        is_slash;
    logic [15:0] cl_hit;     // byte equals content-length prefix char k
    logic [3:0]  http_hit;
  } cls_t;

endpackage

`default_nettype wire

// ===== hw/rtl/http_response_head_parser.sv =====
// ----------------------------------------------------------------------------
// http_response_head_parser
// byte-wide http response status line and header parser
// ----------------------------------------------------------------------------
// usage:
//   in channel: one response byte per beat (data_byte_i) with new_response_i
//   high on the first byte of a response, which clears all parse state.
//   out channel: exactly one result beat per input beat, in order, carrying
//   the event code and the current status, header and body fields.
//   path: an accepted byte is written into the queue, then the parse engine
//   pops it into the result register once the output is free.
//   throughput: one byte per cycle while out_stall_i is low.
//   reset: rst_ni clears the queue, the parse state and the output beat.
//   stall: out_stall_i holds the result register; the two-entry queue keeps
//   taking bytes until full, then in_stall_o rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module http_response_head_parser #(
  parameter int POSITION_BITS = 16,
  parameter int LENGTH_BITS   = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        new_response_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       event_res_o,
  output logic [9:0]       status_code_o,
  output logic [31:0]      name_hash_o,
  output logic             invalid_name_o,
  output logic [15:0]      name_length_o,
  output logic [15:0]      value_offset_o,
  output logic [15:0]      value_length_o,
  output logic [31:0]      body_remaining_o
);

  hrp_pkg::cls_t cls_w, q_data;
  logic          full, push, q_valid, pop;

  // front: byte classification
  hrp_front u_front (
    .data_byte_i    (data_byte_i),
    .new_response_i (new_response_i),
    .cls_o          (cls_w)
  );

  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  // queue decouples intake from the parse engine
  hrp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cls_w),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  // back: parse engine and result register
  hrp_back #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_data_i         (q_data),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_res_o      (event_res_o),
    .status_code_o    (status_code_o),
    .name_hash_o      (name_hash_o),
    .invalid_name_o   (invalid_name_o),
    .name_length_o    (name_length_o),
    .value_offset_o   (value_offset_o),
    .value_length_o   (value_length_o),
    .body_remaining_o (body_remaining_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/hrp_front.sv =====
// ----------------------------------------------------------------------------
// hrp_front
// classifies each incoming byte for the parse engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrp_front (
  input  wire logic [7:0]   data_byte_i,
  input  wire logic         new_response_i,
  output hrp_pkg::cls_t     cls_o
);

  logic [7:0] b;
  logic       upper, lower, num;

  assign b     = data_byte_i;
  assign upper = (b >= "A") && (b <= "Z");
  assign lower = (b >= "a") && (b <= "z");
  assign num   = (b >= "0") && (b <= "9");

  always_comb begin
    cls_o          = '0;
    cls_o.data     = b;
    cls_o.new_resp = new_response_i;
    cls_o.digit    = num;
    if (upper) begin
      cls_o.name_c = b + 8'd32;
    end else if (lower || num || b == "-" || b == "_") begin
      cls_o.name_c = b;
    end
    cls_o.is_cr    = (b == hrp_pkg::ChCr);
    cls_o.is_lf    = (b == hrp_pkg::ChLf);
    cls_o.is_sp    = (b == " ");
    cls_o.is_dot   = (b == ".");
    cls_o.is_colon = (b == ":");
    cls_o.is_slash = (b == "/");
    for (int k = 0; k < hrp_pkg::ClLen; k++) begin
      cls_o.cl_hit[k] = (b == hrp_pkg::ClPrefix[k]);
    end
    for (int k = 0; k < hrp_pkg::HttpLen; k++) begin
      cls_o.http_hit[k] = (b == hrp_pkg::HttpPrefix[k]);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hrp_queue.sv =====
// ----------------------------------------------------------------------------
// hrp_queue
// two-entry queue of classified bytes between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrp_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire hrp_pkg::cls_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output hrp_pkg::cls_t      pop_data_o
);

  hrp_pkg::cls_t mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hrp_back.sv =====
// ----------------------------------------------------------------------------
// hrp_back
// response parse engine and registered result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "http_response_head_parser_assert.svh"

module hrp_back #(
  parameter int POSITION_BITS = 16,
  parameter int LENGTH_BITS   = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire hrp_pkg::cls_t q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [2:0]         event_res_o,
  output logic [9:0]         status_code_o,
  output logic [31:0]        name_hash_o,
  output logic               invalid_name_o,
  output logic [15:0]        name_length_o,
  output logic [15:0]        value_offset_o,
  output logic [15:0]        value_length_o,
  output logic [31:0]        body_remaining_o
);

  localparam int P = POSITION_BITS;
  localparam int L = LENGTH_BITS;

  hrp_pkg::phase_e  phase_q, phase_d;
  hrp_pkg::status_e st_q, st_d;
  hrp_pkg::header_e hd_q, hd_d;
  hrp_pkg::event_e  ev;
  logic [9:0]  code_q, code_d;
  logic [1:0]  cdig_q, cdig_d;
  logic [31:0] hash_q, hash_d;
  logic        bad_q, bad_d;
  logic [P-1:0] bpos_q, bpos_d, lstart_q, lstart_d, vstart_q, vstart_d;
  logic [P-1:0] vend_q, vend_d, nend_q, nend_d, pos;
  logic [3:0]  lcnt_q, lcnt_d, lm_q, lm_d, off;
  logic [2:0]  hm_q, hm_d;
  logic [L-1:0] ldig_q, ldig_d, body_q, body_d;
  logic        lact_q, lact_d, lbad_q, lbad_d;
  logic        do_vc, do_ld;
  logic [L+3:0] ldig_x;
  logic [3:0]  dval;
  hrp_pkg::cls_t c;

  logic        out_valid_q;
  logic [2:0]  ev_q;
  logic [9:0]  oc_q;
  logic [31:0] oh_q, ob_q;
  logic        oi_q;
  logic [15:0] onl_q, ovo_q, ovl_q;
  logic [P-1:0] nl_w, vl_w;
  logic [31:0] nl_x, vl_x, vo_x;
  logic [63:0] body_x;

  assign c     = q_data_i;
  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);
  assign dval  = c.data[3:0];

  always_comb begin
    phase_d = phase_q; st_d = st_q; hd_d = hd_q;
    code_d = code_q; cdig_d = cdig_q; hash_d = hash_q; bad_d = bad_q;
    bpos_d = bpos_q; lstart_d = lstart_q; vstart_d = vstart_q;
    vend_d = vend_q; nend_d = nend_q; lcnt_d = lcnt_q; lm_d = lm_q; hm_d = hm_q;
    ldig_d = ldig_q; lact_d = lact_q; lbad_d = lbad_q; body_d = body_q;
    ev = hrp_pkg::EV_MORE;
    do_vc = 1'b0;
    do_ld = 1'b0;
    off = lcnt_q;
    ldig_x = '0;

    // start of a response clears all parse state
    if (c.new_resp) begin
      phase_d = hrp_pkg::PH_STATUS; st_d = hrp_pkg::ST_H; hd_d = hrp_pkg::H_START;
      code_d = '0; cdig_d = '0; hash_d = '0; bad_d = 1'b0;
      bpos_d = '0; lstart_d = '0; vstart_d = '0; vend_d = '0; nend_d = '0;
      lcnt_d = '0; lm_d = '0; hm_d = '0; ldig_d = '0; lact_d = 1'b0;
      lbad_d = 1'b0; body_d = '0;
      off = '0;
    end
    pos    = bpos_d;
    bpos_d = pos + 1'b1;

    case (phase_d)
      hrp_pkg::PH_STATUS: begin
        case (st_d)
          hrp_pkg::ST_H:     if (c.data == "H") st_d = hrp_pkg::ST_T1;
                             else phase_d = hrp_pkg::PH_ERR;
          hrp_pkg::ST_T1:    if (c.data == "T") st_d = hrp_pkg::ST_T2;
                             else phase_d = hrp_pkg::PH_ERR;
          hrp_pkg::ST_T2:    if (c.data == "T") st_d = hrp_pkg::ST_P;
                             else phase_d = hrp_pkg::PH_ERR;
          hrp_pkg::ST_P:     if (c.data == "P") st_d = hrp_pkg::ST_SLASH;
                             else phase_d = hrp_pkg::PH_ERR;
          hrp_pkg::ST_SLASH: if (c.is_slash) st_d = hrp_pkg::ST_MAJ0;
                             else phase_d = hrp_pkg::PH_ERR;
          hrp_pkg::ST_MAJ0:  if (c.digit && c.data != "0") st_d = hrp_pkg::ST_MAJ;
                             else phase_d = hrp_pkg::PH_ERR;
          hrp_pkg::ST_MAJ: begin
            if (c.is_dot) st_d = hrp_pkg::ST_MIN0;
            else if (!c.digit) phase_d = hrp_pkg::PH_ERR;
          end
          hrp_pkg::ST_MIN0:  if (c.digit) st_d = hrp_pkg::ST_MIN;
                             else phase_d = hrp_pkg::PH_ERR;
          hrp_pkg::ST_MIN: begin
            if (c.is_sp) st_d = hrp_pkg::ST_CODE;
            else if (!c.digit) phase_d = hrp_pkg::PH_ERR;
          end
          hrp_pkg::ST_CODE: begin
            if (!c.is_sp) begin
              if (!c.digit) begin
                phase_d = hrp_pkg::PH_ERR;
              end else begin
                code_d = (code_d << 3) + (code_d << 1) + {6'd0, dval};
                cdig_d = cdig_d + 2'd1;
                if (cdig_d == 2'(hrp_pkg::CodeDigits)) st_d = hrp_pkg::ST_AFTER;
              end
            end
          end
          hrp_pkg::ST_AFTER: begin
            if (c.is_sp || c.is_dot) st_d = hrp_pkg::ST_TEXT;
            else if (c.is_cr) st_d = hrp_pkg::ST_CR;
            else if (c.is_lf) ev = hrp_pkg::EV_STATUS;
            else phase_d = hrp_pkg::PH_ERR;
          end
          hrp_pkg::ST_TEXT: begin
            if (c.is_cr) st_d = hrp_pkg::ST_CR;
            else if (c.is_lf) ev = hrp_pkg::EV_STATUS;
          end
          hrp_pkg::ST_CR: begin
            if (c.is_lf) ev = hrp_pkg::EV_STATUS;
            else phase_d = hrp_pkg::PH_ERR;
          end
          default: phase_d = hrp_pkg::PH_ERR;
        endcase
        if (phase_d == hrp_pkg::PH_ERR) begin
          ev = hrp_pkg::EV_ERR;
        end else if (ev == hrp_pkg::EV_STATUS) begin
          st_d = hrp_pkg::ST_H;
          hd_d = hrp_pkg::H_START;
          phase_d = hrp_pkg::PH_HEAD;
        end
      end

      hrp_pkg::PH_HEAD: begin
        if (hd_d == hrp_pkg::H_START) begin
          lstart_d = pos; lcnt_d = '0; off = '0; lm_d = '0; hm_d = '0;
          ldig_d = '0; lact_d = 1'b0; lbad_d = 1'b0;
        end else begin
          off = lcnt_d;
        end
        if (off < 4'(hrp_pkg::ClLen) && lm_d == off && c.cl_hit[off]) lm_d = lm_d + 4'd1;
        if (off < 4'(hrp_pkg::HttpLen) && hm_d == off[2:0] && c.http_hit[off[1:0]]) begin
          hm_d = hm_d + 3'd1;
        end
        if (lcnt_d < 4'd15) lcnt_d = lcnt_d + 4'd1;

        case (hd_d)
          hrp_pkg::H_START: begin
            if (c.is_cr) begin
              hd_d = hrp_pkg::H_END_CR;
            end else if (c.is_lf) begin
              ev = hrp_pkg::EV_COMPLETE;
            end else begin
              hd_d = hrp_pkg::H_NAME;
              hash_d = {24'd0, c.name_c};
              bad_d = (c.name_c == 8'd0);
            end
          end
          hrp_pkg::H_NAME: begin
            if (c.name_c != 8'd0) begin
              hash_d = (hash_d << 5) - hash_d + {24'd0, c.name_c};
            end else if (c.is_colon) begin
              nend_d = pos;
              hd_d = hrp_pkg::H_PRE;
            end else if (c.is_cr || c.is_lf) begin
              nend_d = pos; vstart_d = pos; vend_d = pos;
              if (c.is_lf) do_ld = 1'b1;
              else hd_d = hrp_pkg::H_ALMOST;
            end else if (c.is_slash && off == 4'(hrp_pkg::HttpLen)
                         && hm_d == 3'(hrp_pkg::HttpLen)) begin
              hd_d = hrp_pkg::H_IGNORE;
            end else begin
              bad_d = 1'b1;
            end
          end
          hrp_pkg::H_PRE: begin
            if (!c.is_sp) begin
              vstart_d = pos;
              if (c.is_cr || c.is_lf) begin
                vend_d = pos;
                if (c.is_lf) do_ld = 1'b1;
                else hd_d = hrp_pkg::H_ALMOST;
              end else begin
                do_vc = 1'b1;
                hd_d = hrp_pkg::H_VALUE;
              end
            end
          end
          hrp_pkg::H_VALUE: begin
            if (c.is_sp) begin
              vend_d = pos; hd_d = hrp_pkg::H_POST;
            end else if (c.is_cr) begin
              vend_d = pos; hd_d = hrp_pkg::H_ALMOST;
            end else if (c.is_lf) begin
              vend_d = pos; do_ld = 1'b1;
            end else begin
              do_vc = 1'b1;
            end
          end
          hrp_pkg::H_POST: begin
            if (c.is_cr) hd_d = hrp_pkg::H_ALMOST;
            else if (c.is_lf) do_ld = 1'b1;
            else if (!c.is_sp) begin
              lbad_d = 1'b1;
              do_vc = 1'b1;
              hd_d = hrp_pkg::H_VALUE;
            end
          end
          hrp_pkg::H_IGNORE: begin
            if (c.is_lf) hd_d = hrp_pkg::H_START;
          end
          hrp_pkg::H_ALMOST: begin
            if (c.is_lf) do_ld = 1'b1;
            else if (!c.is_cr) begin
              phase_d = hrp_pkg::PH_ERR;
              ev = hrp_pkg::EV_ERR;
            end
          end
          default: begin
            if (c.is_lf) ev = hrp_pkg::EV_COMPLETE;
            else begin
              phase_d = hrp_pkg::PH_ERR;
              ev = hrp_pkg::EV_ERR;
            end
          end
        endcase

        // value byte of a possible content-length
        if (do_vc) begin
          lact_d = 1'b1;
          ldig_x = {ldig_d, 3'b000} + {2'b00, ldig_d, 1'b0} + {{L{1'b0}}, dval};
          if (!lbad_d) begin
            if (!c.digit || (|ldig_x[L+3:L])) lbad_d = 1'b1;
            else ldig_d = ldig_x[L-1:0];
          end
        end
        // end of a header line
        if (do_ld) begin
          hd_d = hrp_pkg::H_START;
          ev = hrp_pkg::EV_HEADER;
          if (lm_d == 4'(hrp_pkg::ClLen) && body_d == '0) begin
            if (lbad_d || !lact_d) begin
              phase_d = hrp_pkg::PH_ERR;
              ev = hrp_pkg::EV_ERR;
            end else begin
              body_d = ldig_d;
            end
          end
        end
        // empty line ends the head
        if (ev == hrp_pkg::EV_COMPLETE) begin
          hd_d = hrp_pkg::H_START;
          if (body_d != '0) begin
            phase_d = hrp_pkg::PH_BODY;
            ev = hrp_pkg::EV_BODY;
          end else begin
            phase_d = hrp_pkg::PH_DONE;
          end
        end
      end

      hrp_pkg::PH_BODY: begin
        if (body_d != '0) body_d = body_d - 1'b1;
        if (body_d == '0) begin
          phase_d = hrp_pkg::PH_DONE;
          ev = hrp_pkg::EV_COMPLETE;
        end
      end
      hrp_pkg::PH_DONE: ev = hrp_pkg::EV_COMPLETE;
      default: begin
        phase_d = hrp_pkg::PH_ERR;
        ev = hrp_pkg::EV_ERR;
      end
    endcase
  end

  assign nl_w   = nend_d - lstart_d;
  assign vl_w   = vend_d - vstart_d;
  assign nl_x   = 32'(nl_w);
  assign vl_x   = 32'(vl_w);
  assign vo_x   = 32'(vstart_d);
  assign body_x = 64'(body_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hrp_pkg::PH_STATUS; st_q <= hrp_pkg::ST_H; hd_q <= hrp_pkg::H_START;
      code_q <= '0; cdig_q <= '0; hash_q <= '0; bad_q <= 1'b0;
      bpos_q <= '0; lstart_q <= '0; vstart_q <= '0; vend_q <= '0; nend_q <= '0;
      lcnt_q <= '0; lm_q <= '0; hm_q <= '0; ldig_q <= '0;
      lact_q <= 1'b0; lbad_q <= 1'b0; body_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d; st_q <= st_d; hd_q <= hd_d;
        code_q <= code_d; cdig_q <= cdig_d; hash_q <= hash_d; bad_q <= bad_d;
        bpos_q <= bpos_d; lstart_q <= lstart_d; vstart_q <= vstart_d;
        vend_q <= vend_d; nend_q <= nend_d; lcnt_q <= lcnt_d; lm_q <= lm_d;
        hm_q <= hm_d; ldig_q <= ldig_d; lact_q <= lact_d; lbad_q <= lbad_d;
        body_q <= body_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ev_q  <= ev;
      oc_q  <= code_d;
      oh_q  <= hash_d;
      oi_q  <= bad_d;
      onl_q <= nl_x[15:0];
      ovo_q <= vo_x[15:0];
      ovl_q <= vl_x[15:0];
      ob_q  <= body_x[31:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_res_o      = ev_q;
  assign status_code_o    = oc_q;
  assign name_hash_o      = oh_q;
  assign invalid_name_o   = oi_q;
  assign name_length_o    = onl_q;
  assign value_offset_o   = ovo_q;
  assign value_length_o   = ovl_q;
  assign body_remaining_o = ob_q;

  `HRP_ASSERT(a_err_sticks, pop_o && ev == hrp_pkg::EV_ERR |=> phase_q == hrp_pkg::PH_ERR, "error beat without error phase")
  `HRP_ASSERT(a_done_sticks, pop_o && ev == hrp_pkg::EV_COMPLETE |=> phase_q == hrp_pkg::PH_DONE, "complete beat without done phase")
  `HRP_ASSERT(a_body_nonzero, phase_q == hrp_pkg::PH_BODY |-> body_q != '0, "body phase with nothing left")

endmodule

`default_nettype wire
